// ===== sv/mnt_pkg.sv =====
// shared types and constants of the midi note tracker
// no dependencies; used by every module of the block except mnt_ram
package mnt_pkg;

  // top nibble of the first byte of a message
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_CONTROL  = 4'hB;
  localparam logic [3:0] ST_BEND     = 4'hE;

  // reported message kinds
  localparam logic [2:0] KIND_OTHER    = 3'd0;
  localparam logic [2:0] KIND_NOTE_OFF = 3'd1;
  localparam logic [2:0] KIND_NOTE_ON  = 3'd2;
  localparam logic [2:0] KIND_PEDAL    = 3'd3;
  localparam logic [2:0] KIND_BEND     = 3'd4;

  // item selector
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [7:0] PEDAL_THRESHOLD = 8'd64;
  localparam logic [7:0] BEND_RESET      = 8'd64;

  // completed message, as seen by the note table
  typedef struct packed {
    logic       done;
    logic [2:0] kind;
    logic [7:0] note;
    logic [7:0] value;
  } msg_t;

  // one result item
  typedef struct packed {
    msg_t       msg;
    logic [7:0] velocity;
    logic       released;
    logic       sustained;
    logic [7:0] sustain_level;
    logic [7:0] bend_level;
  } res_t;

endpackage

// ===== sv/midi_note_tracker.sv =====
// midi note tracker: running status parser with a per-note table, top level
// depends on mnt_pkg, mnt_parser, mnt_table (and through it mnt_ram)
//
// Takes one MIDI byte or one table read per transfer and returns exactly one
// result per transfer, at a sustained rate of one item per clock while the
// output is not stalled. A data byte arriving with the byte group empty is
// preceded by the last status byte; every third grouped byte completes a
// message, reported with its kind (note off, note on, pedal, bend, or
// other), its note and value bytes. Note off marks a note released, or
// sustained while the pedal is at 64 or more; note on stores the velocity;
// a pedal message sets the pedal level and on lifting below 64 moves all
// sustained marks to released in the same cycle (the marks are flip-flop
// bit vectors). A read returns one note's velocity and marks; indexes of
// NOTE_COUNT or more read as zero. Every result also carries the pedal and
// bend levels after the item. From input transfer to result valid the item
// passes stage 1, which holds it while the velocity ram read (registered)
// completes, and then the output register. Input ready depends on
// out_tready combinationally, so the pipeline forms no bubbles. Velocity
// entries have per-note valid bits cleared at reset, so no clearing pass.
module midi_note_tracker #(
  parameter int NOTE_COUNT = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // data_byte[7:0], note_index[14:8], zero pad
  input  logic [0:0]  in_tuser,   // func[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // message_note[7:0], message_value[15:8], entry_velocity[23:16],
  // entry_released[24], entry_sustained[25], sustain_level[33:26],
  // bend_level[41:34], zero pad
  output logic [47:0] out_tdata,
  output logic [3:0]  out_tuser   // message_done[0], message_kind[3:1]
);

  logic          in_xfer;
  logic          byte_en;
  logic          rd_en;
  logic [7:0]    data_byte;
  logic [6:0]    note_index;
  mnt_pkg::msg_t msg;

  logic       rd_in_range;
  logic       rd_vel_valid;
  logic       rd_released;
  logic       rd_sustained;
  logic [7:0] rd_velocity;
  logic [7:0] pedal_nxt;
  logic [7:0] bend_nxt;

  // stage 1: item held while the velocity read completes
  logic          s1_valid_r;
  mnt_pkg::res_t s1_res_r;
  logic          s1_vel_hit_r;
  logic          s1_move;

  // output register
  logic          out_valid_r;
  mnt_pkg::res_t out_res_r;
  mnt_pkg::res_t out_res_nxt;

  assign data_byte  = in_tdata[7:0];
  assign note_index = in_tdata[14:8];

  assign s1_move   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_move;
  assign in_xfer   = in_tvalid && in_tready;
  assign byte_en   = in_xfer && in_tuser[0] == mnt_pkg::FUNC_BYTE;
  assign rd_en     = in_xfer && in_tuser[0] == mnt_pkg::FUNC_READ;

  mnt_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (byte_en),
    .data_byte (data_byte),
    .msg       (msg)
  );

  mnt_table #(
    .NOTE_COUNT(NOTE_COUNT)
  ) u_table (
    .clk          (clk),
    .rst_n        (rst_n),
    .msg_en       (byte_en),
    .msg          (msg),
    .rd_en        (rd_en),
    .rd_idx       (note_index),
    .rd_in_range  (rd_in_range),
    .rd_vel_valid (rd_vel_valid),
    .rd_released  (rd_released),
    .rd_sustained (rd_sustained),
    .rd_velocity  (rd_velocity),
    .pedal_nxt    (pedal_nxt),
    .bend_nxt     (bend_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // stage 1 payload; message fields only for bytes, entry fields only for reads
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_res_r.msg           <= byte_en ? msg : '0;
      s1_res_r.velocity      <= 8'd0;
      s1_res_r.released      <= rd_en && rd_in_range && rd_released;
      s1_res_r.sustained     <= rd_en && rd_in_range && rd_sustained;
      s1_res_r.sustain_level <= pedal_nxt;
      s1_res_r.bend_level    <= bend_nxt;
      s1_vel_hit_r           <= rd_en && rd_vel_valid;
    end
  end

  // velocity joins from the ram; unwritten entries read as zero
  always_comb begin
    out_res_nxt          = s1_res_r;
    out_res_nxt.velocity = s1_vel_hit_r ? rd_velocity : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid_r) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_res_r.msg.kind, out_res_r.msg.done};
  assign out_tdata  = {6'd0,
                       out_res_r.bend_level,
                       out_res_r.sustain_level,
                       out_res_r.sustained,
                       out_res_r.released,
                       out_res_r.velocity,
                       out_res_r.msg.value,
                       out_res_r.msg.note};

  // pipeline never refuses input while stage 1 is empty
  assert property (@(posedge clk) disable iff (!rst_n) !s1_valid_r |-> in_tready)
    else $error("input stalled with empty stage");

  // a message result never carries table entry fields
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.msg.done |->
      out_res_r.velocity == 8'd0 && !out_res_r.released && !out_res_r.sustained)
    else $error("entry fields on a message result");

  // a read transfer yields a result without message fields
  assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> s1_valid_r && !s1_res_r.msg.done)
    else $error("read item lost or flagged as message");

endmodule

// ===== sv/mnt_ram.sv =====
// generic simple dual-port ram with registered read
// no dependencies
module mnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic                             rd_en,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/mnt_parser.sv =====
// running status byte grouping and message classification
// depends on mnt_pkg
module mnt_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_en,
  input  logic [7:0]    data_byte,
  output mnt_pkg::msg_t msg
);

  logic [1:0] count_r;
  logic [7:0] grp0_r;
  logic [7:0] grp1_r;
  logic [7:0] last_r;
  logic [2:0] kind;

  always_comb begin
    unique case (grp0_r[7:4])
      mnt_pkg::ST_NOTE_OFF: kind = mnt_pkg::KIND_NOTE_OFF;
      mnt_pkg::ST_NOTE_ON:  kind = mnt_pkg::KIND_NOTE_ON;
      mnt_pkg::ST_CONTROL:  kind = mnt_pkg::KIND_PEDAL;
      mnt_pkg::ST_BEND:     kind = mnt_pkg::KIND_BEND;
      default:              kind = mnt_pkg::KIND_OTHER;
    endcase
  end

  // the third byte completes the group
  always_comb begin
    msg = '0;
    if (count_r == 2'd2) begin
      msg.done  = 1'b1;
      msg.kind  = kind;
      msg.note  = grp1_r;
      msg.value = data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
      last_r  <= 8'd0;
    end else if (byte_en) begin
      if (count_r == 2'd0 && !data_byte[7]) begin
        count_r <= 2'd2;
      end else if (count_r != 2'd2) begin
        count_r <= count_r + 2'd1;
      end else begin
        count_r <= 2'd0;
        last_r  <= grp0_r;
      end
    end
  end

  // group bytes hold no reset, read only where the count shows them written
  always_ff @(posedge clk) begin
    if (byte_en) begin
      if (count_r == 2'd0 && !data_byte[7]) begin
        grp0_r <= last_r;
        grp1_r <= data_byte;
      end else if (count_r == 2'd0) begin
        grp0_r <= data_byte;
      end else if (count_r == 2'd1) begin
        grp1_r <= data_byte;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) count_r != 2'd3)
    else $error("byte group count out of range");

endmodule

// ===== sv/mnt_table.sv =====
// per-note table: velocity ram, released and sustained bit vectors,
// pedal and bend levels; depends on mnt_pkg and mnt_ram
module mnt_table #(
  parameter int NOTE_COUNT = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          msg_en,
  input  mnt_pkg::msg_t msg,
  input  logic          rd_en,
  input  logic [6:0]    rd_idx,
  output logic          rd_in_range,
  output logic          rd_vel_valid,
  output logic          rd_released,
  output logic          rd_sustained,
  output logic [7:0]    rd_velocity,
  output logic [7:0]    pedal_nxt,
  output logic [7:0]    bend_nxt
);

  localparam int IDX_W = NOTE_COUNT > 1 ? $clog2(NOTE_COUNT) : 1;
  localparam logic [7:0] NOTE_LIMIT = 8'(NOTE_COUNT);

  logic [NOTE_COUNT-1:0] released_r;
  logic [NOTE_COUNT-1:0] sustained_r;
  logic [NOTE_COUNT-1:0] vel_valid_r;
  logic [7:0]            pedal_r;
  logic [7:0]            bend_r;

  logic             note_in_range;
  logic [IDX_W-1:0] note_addr;
  logic [IDX_W-1:0] rd_addr;
  logic             note_off;
  logic             note_on;
  logic             pedal_msg;
  logic             fold;

  assign note_in_range = msg.note < NOTE_LIMIT;
  assign note_addr     = msg.note[IDX_W-1:0];
  assign rd_addr       = rd_idx[IDX_W-1:0];
  assign rd_in_range   = {1'b0, rd_idx} < NOTE_LIMIT;

  assign note_off  = msg_en && msg.done && msg.kind == mnt_pkg::KIND_NOTE_OFF
                     && note_in_range;
  assign note_on   = msg_en && msg.done && msg.kind == mnt_pkg::KIND_NOTE_ON
                     && note_in_range;
  assign pedal_msg = msg_en && msg.done && msg.kind == mnt_pkg::KIND_PEDAL;
  // pedal lifted: sustained notes become released
  assign fold      = pedal_msg && pedal_r >= mnt_pkg::PEDAL_THRESHOLD
                     && msg.value < mnt_pkg::PEDAL_THRESHOLD;

  assign pedal_nxt = pedal_msg ? msg.value : pedal_r;
  assign bend_nxt  = (msg_en && msg.done && msg.kind == mnt_pkg::KIND_BEND)
                     ? msg.value : bend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      released_r  <= '0;
      sustained_r <= '0;
      vel_valid_r <= '0;
      pedal_r     <= 8'd0;
      bend_r      <= mnt_pkg::BEND_RESET;
    end else begin
      pedal_r <= pedal_nxt;
      bend_r  <= bend_nxt;
      if (note_off) begin
        if (pedal_r < mnt_pkg::PEDAL_THRESHOLD) begin
          released_r[note_addr] <= 1'b1;
        end else begin
          sustained_r[note_addr] <= 1'b1;
        end
      end
      if (fold) begin
        released_r  <= released_r | sustained_r;
        sustained_r <= '0;
      end
      if (note_on) begin
        vel_valid_r[note_addr] <= 1'b1;
      end
    end
  end

  assign rd_vel_valid = rd_in_range && vel_valid_r[rd_addr];
  assign rd_released  = rd_in_range && released_r[rd_addr];
  assign rd_sustained = rd_in_range && sustained_r[rd_addr];

  mnt_ram #(
    .WIDTH(8),
    .DEPTH(NOTE_COUNT)
  ) u_vel_ram (
    .clk     (clk),
    .wr_en   (note_on),
    .wr_addr (note_addr),
    .wr_data (msg.value),
    .rd_en   (rd_en && rd_in_range),
    .rd_addr (rd_addr),
    .rd_data (rd_velocity)
  );

  // sustained marks exist only while the pedal is held
  assert property (@(posedge clk) disable iff (!rst_n)
    pedal_r < mnt_pkg::PEDAL_THRESHOLD |-> sustained_r == '0)
    else $error("sustained mark with pedal up");

  assert property (@(posedge clk) disable iff (!rst_n)
    fold |=> sustained_r == '0)
    else $error("sustained marks not cleared on pedal release");

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for midi_note_tracker: directed table, then random midi traffic
// predicts each result with its own copy of the parser and note table, or takes it literally from a directed row
// depends on mnt_pkg and the midi_note_tracker rtl
module tb_top;

  localparam int NOTE_COUNT      = 128;
  localparam int STALL_LIMIT     = 1000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int SETTLE_CYCLES   = 8;

  // status nibbles of the kinds the block drops
  localparam logic [3:0] ST_POLY_PRESSURE = 4'hA;
  localparam logic [3:0] ST_PROGRAM       = 4'hC;
  localparam logic [3:0] ST_CHAN_PRESSURE = 4'hD;
  localparam logic [3:0] ST_SYSTEM        = 4'hF;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // data_byte[7:0], note_index[14:8], zero pad
  logic [0:0]  in_tuser;   // func[0]
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // note, value, velocity, released, sustained, sustain, bend
  logic [3:0]  out_tuser;  // message_done[0], message_kind[3:1]

  midi_note_tracker #(.NOTE_COUNT(NOTE_COUNT)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // shadow of the parser and note table
  logic [7:0]            grp_status;
  logic [7:0]            grp_note;
  logic [1:0]            grp_count;
  logic [7:0]            run_status;
  logic [7:0]            pedal;
  logic [7:0]            bend;
  logic [7:0]            velocity_tbl [NOTE_COUNT];
  logic [NOTE_COUNT-1:0] released_tbl;
  logic [NOTE_COUNT-1:0] sustained_tbl;

  mnt_pkg::res_t pending_results[$];
  int unsigned   mismatch_count = 0;
  int unsigned   items_sent     = 0;
  int unsigned   feed_idle_pct  = 34;
  int unsigned   drain_idle_pct = 73;
  bit            hold_off_req   = 1'b0;

  // one midi byte or one table read, returns the result the block must give
  function automatic mnt_pkg::res_t track_midi_item(logic func, logic [7:0] b,
                                                    logic [6:0] idx);
    mnt_pkg::res_t r;
    r = '0;
    if (func == mnt_pkg::FUNC_BYTE) begin
      if (grp_count == 2'd0 && !b[7]) begin
        // running status: data byte with an empty group
        grp_status = run_status;
        grp_note   = b;
        grp_count  = 2'd2;
      end else if (grp_count == 2'd0) begin
        grp_status = b;
        grp_count  = 2'd1;
      end else if (grp_count == 2'd1) begin
        grp_note  = b;
        grp_count = 2'd2;
      end else begin
        grp_count   = 2'd0;
        run_status  = grp_status;
        r.msg.done  = 1'b1;
        r.msg.note  = grp_note;
        r.msg.value = b;
        case (grp_status[7:4])
          mnt_pkg::ST_NOTE_OFF: begin
            r.msg.kind = mnt_pkg::KIND_NOTE_OFF;
            if (grp_note < NOTE_COUNT) begin
              if (pedal < mnt_pkg::PEDAL_THRESHOLD) released_tbl[grp_note[6:0]] = 1'b1;
              else sustained_tbl[grp_note[6:0]] = 1'b1;
            end
          end
          mnt_pkg::ST_NOTE_ON: begin
            r.msg.kind = mnt_pkg::KIND_NOTE_ON;
            if (grp_note < NOTE_COUNT) velocity_tbl[grp_note[6:0]] = b;
          end
          mnt_pkg::ST_CONTROL: begin
            r.msg.kind = mnt_pkg::KIND_PEDAL;
            // pedal lift folds every sustained mark into released
            if (pedal >= mnt_pkg::PEDAL_THRESHOLD && b < mnt_pkg::PEDAL_THRESHOLD) begin
              released_tbl  = released_tbl | sustained_tbl;
              sustained_tbl = '0;
            end
            pedal = b;
          end
          mnt_pkg::ST_BEND: begin
            r.msg.kind = mnt_pkg::KIND_BEND;
            bend = b;
          end
          default: r.msg.kind = mnt_pkg::KIND_OTHER;
        endcase
      end
    end else if (idx < NOTE_COUNT) begin
      r.velocity  = velocity_tbl[idx];
      r.released  = released_tbl[idx];
      r.sustained = sustained_tbl[idx];
    end
    r.sustain_level = pedal;
    r.bend_level    = bend;
    return r;
  endfunction

  // offer one item, wait for its transfer, queue its expected result
  task automatic send_item(logic func, logic [7:0] b, logic [6:0] idx,
                           bit literal, mnt_pkg::res_t literal_res);
    mnt_pkg::res_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < feed_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {1'b0, idx, b};
    do @(posedge clk); while (!in_tready);
    predicted = track_midi_item(func, b, idx);
    pending_results.push_back(literal ? literal_res : predicted);
    items_sent++;
  endtask

  // unused fields carry random bits
  task automatic send_byte(logic [7:0] b);
    send_item(mnt_pkg::FUNC_BYTE, b, 7'($urandom_range(127)), 1'b0, '0);
  endtask

  task automatic send_read(logic [6:0] idx);
    send_item(mnt_pkg::FUNC_READ, 8'($urandom_range(255)), idx, 1'b0, '0);
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // one message of three bytes, status byte left out now and then under running status
  task automatic send_random_message();
    logic [3:0] kind_nib;
    logic [3:0] channel;
    logic [7:0] status;
    logic [7:0] note;
    logic [7:0] value;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) kind_nib = mnt_pkg::ST_NOTE_ON;
    else if (pick < 55) kind_nib = mnt_pkg::ST_NOTE_OFF;
    else if (pick < 75) kind_nib = mnt_pkg::ST_CONTROL;
    else if (pick < 88) kind_nib = mnt_pkg::ST_BEND;
    else begin
      case ($urandom_range(3))
        0: kind_nib = ST_POLY_PRESSURE;
        1: kind_nib = ST_PROGRAM;
        2: kind_nib = ST_CHAN_PRESSURE;
        default: kind_nib = ST_SYSTEM;
      endcase
    end
    channel = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'h0;
    status  = {kind_nib, channel};
    // keep notes in a small set so reads see them, some out of range
    note = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
    if (kind_nib == mnt_pkg::ST_CONTROL) begin
      case ($urandom_range(5))
        0: value = 8'd0;
        1: value = mnt_pkg::PEDAL_THRESHOLD - 8'd1;
        2: value = mnt_pkg::PEDAL_THRESHOLD;
        3: value = 8'd127;
        4: value = 8'($urandom_range(255));
        default: value = 8'($urandom_range(127));
      endcase
    end else begin
      value = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(127));
    end
    if (!(status == run_status && grp_count == 2'd0 && !note[7] && $urandom_range(1) == 1))
      send_byte(status);
    send_byte(note);
    send_byte(value);
  endtask

  task automatic run_random_traffic(int unsigned last_item);
    int unsigned pick;
    hold_off_req = 1'b1;
    while (items_sent < last_item) begin
      pick = $urandom_range(99);
      if (pick < 65) send_random_message();
      else if (pick < 85) begin
        if ($urandom_range(4) == 0) send_read(7'($urandom_range(127)));
        else send_read(7'($urandom_range(15)));
      end else send_byte(8'($urandom_range(255)));
    end
  endtask

  // directed stimulus, literal expectations only where obvious
  typedef struct packed {
    logic          func;
    logic [7:0]    b;
    logic [6:0]    idx;
    logic          literal;
    mnt_pkg::res_t res;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 29;
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // table and levels right after reset
    '{mnt_pkg::FUNC_READ, 8'h00, 7'd0, 1'b1,
      '{'{1'b0, mnt_pkg::KIND_OTHER, 8'h00, 8'h00},
        8'h00, 1'b0, 1'b0, 8'h00, mnt_pkg::BEND_RESET}},
    // running status from reset uses a zero status byte, a dropped kind
    '{mnt_pkg::FUNC_BYTE, 8'h12, 7'd0, 1'b1,
      '{'{1'b0, mnt_pkg::KIND_OTHER, 8'h00, 8'h00},
        8'h00, 1'b0, 1'b0, 8'h00, mnt_pkg::BEND_RESET}},
    '{mnt_pkg::FUNC_BYTE, 8'h34, 7'd0, 1'b1,
      '{'{1'b1, mnt_pkg::KIND_OTHER, 8'h12, 8'h34},
        8'h00, 1'b0, 1'b0, 8'h00, mnt_pkg::BEND_RESET}},
    // note on top note, status byte inside the group as velocity
    '{mnt_pkg::FUNC_BYTE, 8'h90, 7'd0, 1'b0, '0},
    '{mnt_pkg::FUNC_BYTE, 8'h7F, 7'd0, 1'b0, '0},
    '{mnt_pkg::FUNC_BYTE, 8'hFF, 7'd0, 1'b0, '0},
    // running status note on, note 0 velocity 0
    '{mnt_pkg::FUNC_BYTE, 8'h00, 7'd0, 1'b0, '0},
    '{mnt_pkg::FUNC_BYTE, 8'h00, 7'd0, 1'b0, '0},
    // pedal down
    '{mnt_pkg::FUNC_BYTE, 8'hB0, 7'd0, 1'b0, '0},
    '{mnt_pkg::FUNC_BYTE, 8'h40, 7'd0, 1'b0, '0},
    '{mnt_pkg::FUNC_BYTE, 8'h7F, 7'd0, 1'b0, '0},
    // note off under pedal goes to sustained
    '{mnt_pkg::FUNC_BYTE, 8'h80, 7'd0, 1'b0, '0},
    '{mnt_pkg::FUNC_BYTE, 8'h00, 7'd0, 1'b0, '0},
    '{mnt_pkg::FUNC_BYTE, 8'h00, 7'd0, 1'b0, '0},
    '{mnt_pkg::FUNC_READ, 8'h00, 7'd0, 1'b0, '0},
    // pedal lift folds sustained into released
    '{mnt_pkg::FUNC_BYTE, 8'hB0, 7'd0, 1'b0, '0},
    '{mnt_pkg::FUNC_BYTE, 8'h40, 7'd0, 1'b0, '0},
    '{mnt_pkg::FUNC_BYTE, 8'h00, 7'd0, 1'b0, '0},
    '{mnt_pkg::FUNC_READ, 8'h00, 7'd0, 1'b0, '0},
    // bend to zero
    '{mnt_pkg::FUNC_BYTE, 8'hE0, 7'd0, 1'b0, '0},
    '{mnt_pkg::FUNC_BYTE, 8'h7F, 7'd0, 1'b0, '0},
    '{mnt_pkg::FUNC_BYTE, 8'h00, 7'd0, 1'b0, '0},
    // system kind is dropped but still reported
    '{mnt_pkg::FUNC_BYTE, 8'hF0, 7'd0, 1'b0, '0},
    '{mnt_pkg::FUNC_BYTE, 8'h80, 7'd0, 1'b0, '0},
    '{mnt_pkg::FUNC_BYTE, 8'h80, 7'd0, 1'b0, '0},
    // note byte out of range leaves the table alone
    '{mnt_pkg::FUNC_BYTE, 8'h90, 7'd0, 1'b0, '0},
    '{mnt_pkg::FUNC_BYTE, 8'hC8, 7'd0, 1'b0, '0},
    '{mnt_pkg::FUNC_BYTE, 8'h55, 7'd0, 1'b0, '0},
    '{mnt_pkg::FUNC_READ, 8'h00, 7'd127, 1'b0, '0}
  };

  // receiver: random stalls plus one long hold-off per request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= drain_idle_pct);
      end
    end
  end

  function automatic void check_field(string name, int unsigned expv, int unsigned actv);
    if (expv != actv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    mnt_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("message_done", want.msg.done, out_tuser[0]);
        check_field("message_kind", want.msg.kind, out_tuser[3:1]);
        check_field("message_note", want.msg.note, out_tdata[7:0]);
        check_field("message_value", want.msg.value, out_tdata[15:8]);
        check_field("entry_velocity", want.velocity, out_tdata[23:16]);
        check_field("entry_released", want.released, out_tdata[24]);
        check_field("entry_sustained", want.sustained, out_tdata[25]);
        check_field("sustain_level", want.sustain_level, out_tdata[33:26]);
        check_field("bend_level", want.bend_level, out_tdata[41:34]);
      end
    end
  end

  // ends the run when no transfer happens for too long
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("midi_note_tracker: mismatch");
    $finish;
  end

  initial begin
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    rst_n         = 1'b0;
    grp_status    = '0;
    grp_note      = '0;
    grp_count     = '0;
    run_status    = '0;
    pedal         = '0;
    bend          = mnt_pkg::BEND_RESET;
    released_tbl  = '0;
    sustained_tbl = '0;
    foreach (velocity_tbl[i]) velocity_tbl[i] = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].func, directed_rows[i].b, directed_rows[i].idx,
                directed_rows[i].literal, directed_rows[i].res);
    pause_until_drained();

    run_random_traffic(560);
    pause_until_drained();

    feed_idle_pct  = 73;
    drain_idle_pct = 34;
    run_random_traffic(1090);
    pause_until_drained();

    // full rate both sides
    feed_idle_pct  = 0;
    drain_idle_pct = 0;
    run_random_traffic(1620);
    pause_until_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("midi_note_tracker: match");
    else
      $display("midi_note_tracker: mismatch");
    $finish;
  end

endmodule
